[rtl/core/psu_pkg.sv]
package psu_pkg;

    // particle kinds
    localparam logic [2:0] KIND_STATIC   = 3'd0;
    localparam logic [2:0] KIND_GRAV     = 3'd1;
    localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
    localparam logic [2:0] KIND_FIRE     = 3'd3;
    localparam logic [2:0] KIND_EXPLODE  = 3'd4;
    localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
    localparam logic [2:0] KIND_BLOB     = 3'd6;
    localparam logic [2:0] KIND_BLOB2    = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_TIME = 2'd0;
    localparam logic [1:0] CFG_GRAVITY    = 2'd1;
    localparam logic [1:0] CFG_NOW_TIME   = 2'd2;

    localparam logic [15:0] FRAME_TIME_RST = 16'd1092;
    localparam logic [11:0] GRAVITY_RST    = 12'd800;

    // ramp step multipliers and end points (table index units)
    localparam logic [4:0] STEP_FIRE     = 5'd5;
    localparam logic [4:0] STEP_EXPLODE  = 5'd10;
    localparam logic [4:0] STEP_EXPLODE2 = 5'd15;
    localparam logic [3:0] FIRE_END      = 4'd6;
    localparam logic [3:0] EXPLODE_END   = 4'd8;

    // floor(q / 5) = (q * DIV5_MUL) >> DIV5_SHIFT for q < 2^26
    localparam logic [26:0] DIV5_MUL   = 27'd107374183;
    localparam int          DIV5_SHIFT = 29;

    function automatic logic [7:0] fire_color(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6d;
            4'd1:    c = 8'h6b;
            4'd2:    c = 8'h06;
            4'd3:    c = 8'h05;
            4'd4:    c = 8'h04;
            4'd5:    c = 8'h03;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] explode_color(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6f;
            4'd1:    c = 8'h6d;
            4'd2:    c = 8'h6b;
            4'd3:    c = 8'h69;
            4'd4:    c = 8'h67;
            4'd5:    c = 8'h65;
            4'd6:    c = 8'h63;
            4'd7:    c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] explode2_color(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6f;
            4'd1:    c = 8'h6e;
            4'd2:    c = 8'h6d;
            4'd3:    c = 8'h6c;
            4'd4:    c = 8'h6b;
            4'd5:    c = 8'h6a;
            4'd6:    c = 8'h68;
            4'd7:    c = 8'h66;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/particle_state_update.sv]
// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+-------------------------------------
// input     | i_in_valid   | o_in_stall   | i_kind .. i_expire_in
// output    | o_out_valid  | i_out_stall  | o_removed .. o_expire_out
// config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Three register stages: products, then grav divide and sums, then output.
// One item per cycle while the output does not stall; an accepted input passes the
// stage-1 and stage-2 valid registers into the stage-3 register that drives o_out_valid.
// Latency is set by the velocity-times-frame multipliers and the grav divide.
// Synchronous active-low reset clears valid bits and loads config defaults.
// A stall on the output fills bubbles first and then holds every stage.
module particle_state_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_ramp_in,
    input  logic [7:0]  i_color_in,
    input  logic signed [31:0] i_pos_x_in,
    input  logic signed [31:0] i_pos_y_in,
    input  logic signed [31:0] i_pos_z_in,
    input  logic signed [31:0] i_vel_x_in,
    input  logic signed [31:0] i_vel_y_in,
    input  logic signed [31:0] i_vel_z_in,
    input  logic signed [31:0] i_expire_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_removed,
    output logic [15:0] o_ramp_out,
    output logic [7:0]  o_color_out,
    output logic signed [31:0] o_pos_x_out,
    output logic signed [31:0] o_pos_y_out,
    output logic signed [31:0] o_pos_z_out,
    output logic signed [31:0] o_vel_x_out,
    output logic signed [31:0] o_vel_y_out,
    output logic signed [31:0] o_vel_z_out,
    output logic signed [31:0] o_expire_out
);
    import psu_pkg::*;

    // configuration registers
    logic [15:0] r_frame_time;
    logic [11:0] r_gravity;
    logic [30:0] r_now_time;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= FRAME_TIME_RST;
            r_gravity    <= GRAVITY_RST;
            r_now_time   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_TIME: r_frame_time <= i_cfg_data[15:0];
                CFG_GRAVITY:    r_gravity    <= i_cfg_data[11:0];
                CFG_NOW_TIME:   r_now_time   <= i_cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // stage enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    assign en3 = !r_v3 || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    // stage 1: products, ramp step, removal test
    logic signed [16:0] f_s;
    logic [19:0]        ramp_prod;
    logic [16:0]        ramp_sum;
    logic [15:0]        n_ramp1;
    assign f_s = $signed({1'b0, r_frame_time});

    always_comb begin
        case (i_kind)
            KIND_FIRE:     ramp_prod = r_frame_time * STEP_FIRE;
            KIND_EXPLODE:  ramp_prod = r_frame_time * STEP_EXPLODE;
            KIND_EXPLODE2: ramp_prod = r_frame_time * STEP_EXPLODE2;
            default:       ramp_prod = '0;
        endcase
        ramp_sum = {1'b0, i_ramp_in} + {1'b0, ramp_prod[19:4]};
        n_ramp1  = ramp_sum[16] ? 16'hffff : ramp_sum[15:0];
    end

    logic [2:0]  r_kind1;
    logic [15:0] r_ramp_in1, r_ramp1;
    logic [7:0]  r_color1;
    logic signed [31:0] r_pos1 [3];
    logic signed [31:0] r_vel1 [3];
    logic signed [48:0] r_prod1 [3];
    logic signed [31:0] r_expire1;
    logic        r_rem1;
    logic [27:0] r_gprod1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en1) r_v1 <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_kind1    <= i_kind;
            r_ramp_in1 <= i_ramp_in;
            r_ramp1    <= n_ramp1;
            r_color1   <= i_color_in;
            r_pos1[0]  <= i_pos_x_in;
            r_pos1[1]  <= i_pos_y_in;
            r_pos1[2]  <= i_pos_z_in;
            r_vel1[0]  <= i_vel_x_in;
            r_vel1[1]  <= i_vel_y_in;
            r_vel1[2]  <= i_vel_z_in;
            r_prod1[0] <= i_vel_x_in * f_s;
            r_prod1[1] <= i_vel_y_in * f_s;
            r_prod1[2] <= i_vel_z_in * f_s;
            r_expire1  <= i_expire_in;
            r_rem1     <= i_expire_in < $signed({1'b0, r_now_time});
            r_gprod1   <= r_frame_time * r_gravity;
        end
    end

    // stage 2: grav divide by 20, position sums, velocity scaling, color
    logic [52:0] gdiv;
    logic signed [31:0] n_pos2 [3];
    logic signed [31:0] n_vel2 [3];
    logic [7:0]  n_color2;
    logic signed [31:0] n_expire2;
    logic [15:0] n_ramp2;
    logic        n_gadd2, n_gsub2;
    logic [3:0]  ridx;

    assign gdiv = r_gprod1[27:2] * DIV5_MUL;
    assign ridx = r_ramp1[15:12];

    always_comb begin
        n_color2  = r_color1;
        n_expire2 = r_expire1;
        n_ramp2   = r_ramp_in1;
        n_gadd2   = 1'b0;
        n_gsub2   = 1'b0;
        for (int a = 0; a < 3; a++) begin
            n_pos2[a] = r_pos1[a];
            n_vel2[a] = r_vel1[a];
        end
        if (!r_rem1) begin
            for (int a = 0; a < 3; a++)
                n_pos2[a] = r_pos1[a] + r_prod1[a][47:16];
            case (r_kind1)
                KIND_FIRE: begin
                    n_ramp2 = r_ramp1;
                    if (ridx >= FIRE_END) n_expire2 = -32'sd1;
                    else n_color2 = fire_color(ridx);
                    n_gadd2 = 1'b1;
                end
                KIND_EXPLODE: begin
                    n_ramp2 = r_ramp1;
                    if (ridx >= EXPLODE_END) n_expire2 = -32'sd1;
                    else n_color2 = explode_color(ridx);
                    for (int a = 0; a < 3; a++)
                        n_vel2[a] = r_vel1[a] + r_prod1[a][45:14];
                    n_gsub2 = 1'b1;
                end
                KIND_EXPLODE2: begin
                    n_ramp2 = r_ramp1;
                    if (ridx >= EXPLODE_END) n_expire2 = -32'sd1;
                    else n_color2 = explode2_color(ridx);
                    for (int a = 0; a < 3; a++)
                        n_vel2[a] = r_vel1[a] - r_prod1[a][47:16];
                    n_gsub2 = 1'b1;
                end
                KIND_BLOB: begin
                    for (int a = 0; a < 3; a++)
                        n_vel2[a] = r_vel1[a] + r_prod1[a][45:14];
                    n_gsub2 = 1'b1;
                end
                KIND_BLOB2: begin
                    for (int a = 0; a < 2; a++)
                        n_vel2[a] = r_vel1[a] - r_prod1[a][45:14];
                    n_gsub2 = 1'b1;
                end
                KIND_GRAV, KIND_SLOWGRAV: n_gsub2 = 1'b1;
                default: ;
            endcase
        end
    end

    logic [23:0] r_grav2;
    logic signed [31:0] r_pos2 [3];
    logic signed [31:0] r_vel2 [3];
    logic [7:0]  r_color2;
    logic signed [31:0] r_expire2;
    logic [15:0] r_ramp2;
    logic        r_gadd2, r_gsub2, r_rem2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en2) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_grav2   <= gdiv[DIV5_SHIFT +: 24];
            r_pos2    <= n_pos2;
            r_vel2    <= n_vel2;
            r_color2  <= n_color2;
            r_expire2 <= n_expire2;
            r_ramp2   <= n_ramp2;
            r_gadd2   <= n_gadd2;
            r_gsub2   <= n_gsub2;
            r_rem2    <= r_rem1;
        end
    end

    // stage 3: gravity on vertical velocity, output register
    logic signed [31:0] n_vel_z3;
    always_comb begin
        case ({r_gadd2, r_gsub2})
            2'b10:   n_vel_z3 = r_vel2[2] + $signed({8'd0, r_grav2});
            2'b01:   n_vel_z3 = r_vel2[2] - $signed({8'd0, r_grav2});
            default: n_vel_z3 = r_vel2[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            o_removed    <= r_rem2;
            o_ramp_out   <= r_ramp2;
            o_color_out  <= r_color2;
            o_pos_x_out  <= r_pos2[0];
            o_pos_y_out  <= r_pos2[1];
            o_pos_z_out  <= r_pos2[2];
            o_vel_x_out  <= r_vel2[0];
            o_vel_y_out  <= r_vel2[1];
            o_vel_z_out  <= n_vel_z3;
            o_expire_out <= r_expire2;
        end
    end

    assign o_out_valid = r_v3;

`ifndef SYNTH
    // input stalls only when stage 1 holds an item that cannot move
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a bubble in the pipeline");

    // a held output item is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_out_stall) |=> r_v3)
        else $error("stalled output item lost");

    // removal flag reaches the output with its item
    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_rem2 && en3) |=> (o_out_valid && o_removed))
        else $error("removal flag lost between stages");
`endif

endmodule
